// ===== rtl/nmeafc_pkg.sv =====
// Shared constants, types and helper functions for the NMEA sentence framer.
package nmeafc_pkg;

  // Default limit on the number of characters in one sentence.
  localparam int MAX_SENTENCE_DEF = 128;

  // Framing characters.
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Tail of a sentence is '*', two hex digits, CR, LF.
  localparam int TAIL_LEN  = 5;
  // A sentence must hold more than this many characters to close.
  localparam int MIN_FRAME = 6;

  // Width of the position output.
  localparam int POS_W = 7;

  // Code returned by hex_value for a character that is not a hex digit.
  localparam logic [4:0] HEX_NONE = 5'd16;

  // Tail check results handed from the checksum unit to the top level.
  typedef struct packed {
    logic       tail_match;
    logic       sum_ok;
    logic [7:0] rx_sum;
    logic [7:0] calc_sum;
  } frame_check_t;

  // Value of one hex digit, or HEX_NONE when the character is not one.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_NONE;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h61 + 8'd10);
    end
    return v;
  endfunction

endpackage

// ===== rtl/nmeafc_tail_check.sv =====
// Sentence tail detection and checksum compare for the NMEA framer.
module nmeafc_tail_check (
  input  logic [7:0]                tail [nmeafc_pkg::TAIL_LEN],
  input  logic [7:0]                run_xor,
  output nmeafc_pkg::frame_check_t  chk
);
  import nmeafc_pkg::*;

  logic [4:0] h1;
  logic [4:0] h2;
  logic [7:0] rx_sum;
  logic [7:0] calc_sum;

  // The last five characters must read '*', any, any, CR, LF; the two checksum characters are not checked here.
  assign chk.tail_match = (tail[0] == CH_STAR) && (tail[3] == CH_CR) && (tail[4] == CH_LF);

  // Decode the received checksum; a non-hex character ends the number.
  assign h1 = hex_value(tail[1]);
  assign h2 = hex_value(tail[2]);

  always_comb begin
    priority if (h1[4]) begin
      rx_sum = 8'h00;
    end else if (h2[4]) begin
      rx_sum = {4'h0, h1[3:0]};
    end else begin
      rx_sum = {h1[3:0], h2[3:0]};
    end
  end

  // Remove the leading '$' and the five tail characters from the running XOR.
  assign calc_sum = run_xor ^ CH_START ^ tail[0] ^ tail[1] ^ tail[2] ^ tail[3] ^ tail[4];

  assign chk.rx_sum   = rx_sum;
  assign chk.calc_sum = calc_sum;
  assign chk.sum_ok   = (rx_sum == calc_sum);

endmodule

// ===== rtl/nmea_sentence_framer_checker.sv =====
// NMEA 0183 sentence framer and checksum checker, top level.
// One received character is taken per clock on the rx channel while rx_stall
// is low; it passes an input register, then the framing state update and
// tail check, and lands in the result register; a stalled result raises
// rx_stall while the input register holds an accepted character. A '$'
// always opens a new sentence; characters outside a sentence give no result.
// Each character of an open sentence is reported with its position (masked
// to 7 bits). The character completing a '*hh CR LF' tail of a sentence of
// more than six characters carries frame_end with the received and computed
// checksums. A character arriving once the sentence already holds
// MAX_SENTENCE characters is dropped and the framer goes idle.
module nmea_sentence_framer_checker #(
  parameter int MAX_SENTENCE = nmeafc_pkg::MAX_SENTENCE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] in_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic [6:0] position,
  output logic       frame_end,
  output logic       checksum_ok,
  output logic [7:0] received_sum,
  output logic [7:0] computed_sum
);
  import nmeafc_pkg::*;

  localparam int LEN_W = $clog2(MAX_SENTENCE + 1);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Framing state.
  logic             tracking;
  logic [LEN_W-1:0] len_cnt;
  logic [7:0]       run_xor;
  logic [7:0]       tail [TAIL_LEN];

  // Next-state working values.
  logic             advance;
  logic             start;
  logic             trk_eff;
  logic [LEN_W-1:0] len_eff;
  logic [7:0]       xor_eff;
  logic             overflow;
  logic             produce;
  logic [LEN_W-1:0] len_next;
  logic [7:0]       xor_next;
  logic [7:0]       tail_next [TAIL_LEN];
  logic             long_enough;
  logic             closes;
  logic [LEN_W+POS_W-1:0] len_ext;
  frame_check_t     chk;

  // The input stage moves on whenever the result register can take a value.
  assign advance  = !(res_valid && res_stall);
  assign rx_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_valid && !rx_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      s1_byte <= in_byte;
    end
  end

  // A '$' restarts the sentence before the character is counted.
  assign start    = (s1_byte == CH_START);
  assign trk_eff  = start || tracking;
  assign len_eff  = start ? '0 : len_cnt;
  assign xor_eff  = start ? 8'h00 : run_xor;
  assign overflow = (len_eff >= LEN_W'(MAX_SENTENCE));
  assign produce  = s1_valid && trk_eff && !overflow;

  assign len_next = len_eff + LEN_W'(1);
  assign xor_next = xor_eff ^ s1_byte;

  // Shift the character into the tail window, oldest at index 0.
  always_comb begin
    for (int i = 0; i < TAIL_LEN - 1; i++) begin
      tail_next[i] = start ? 8'h00 : tail[i+1];
    end
    tail_next[TAIL_LEN-1] = s1_byte;
  end

  nmeafc_tail_check u_tail_check (
    .tail    (tail_next),
    .run_xor (xor_next),
    .chk     (chk)
  );

  assign long_enough = (len_next > LEN_W'(MIN_FRAME));
  assign closes      = long_enough && chk.tail_match;
  assign len_ext     = {{POS_W{1'b0}}, len_eff};

  // Framing state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      tracking <= 1'b0;
      len_cnt  <= '0;
    end else if (s1_valid && advance) begin
      if (!trk_eff) begin
        tracking <= 1'b0;
        len_cnt  <= '0;
      end else if (overflow || closes) begin
        tracking <= 1'b0;
        len_cnt  <= '0;
      end else begin
        tracking <= 1'b1;
        len_cnt  <= len_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_xor <= 8'h00;
      for (int i = 0; i < TAIL_LEN; i++) begin
        tail[i] <= 8'h00;
      end
    end else if (produce && advance) begin
      run_xor <= xor_next;
      for (int i = 0; i < TAIL_LEN; i++) begin
        tail[i] <= tail_next[i];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= produce;
    end
  end

  always_ff @(posedge clk) begin
    if (produce && advance) begin
      out_byte     <= s1_byte;
      position     <= len_ext[POS_W-1:0];
      frame_end    <= closes;
      checksum_ok  <= closes && chk.sum_ok;
      received_sum <= closes ? chk.rx_sum : 8'h00;
      computed_sum <= closes ? chk.calc_sum : 8'h00;
    end
  end

endmodule

// ===== rtl/nmeafc_checker.sv =====
// Port-level assertions for the NMEA sentence framer, bound to the top level.
module nmeafc_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_stall,
  input logic [7:0] out_byte,
  input logic [6:0] position,
  input logic       frame_end,
  input logic       checksum_ok,
  input logic [7:0] received_sum,
  input logic [7:0] computed_sum
);
  import nmeafc_pkg::*;

  // A stalled result holds its value until it is taken.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_byte) && $stable(position)
      && $stable(frame_end) && $stable(computed_sum))
    else $error("stalled result changed");

  // A sentence can only close on its LF character.
  a_end_on_lf: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_end |-> out_byte == CH_LF)
    else $error("frame_end on a character other than LF");

  // Checksum fields are zero outside the closing character.
  a_sum_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !frame_end |-> !checksum_ok && received_sum == 8'h00
      && computed_sum == 8'h00)
    else $error("checksum fields set without frame_end");

  // The match flag agrees with the two reported sums.
  a_sum_match: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_end |-> checksum_ok == (received_sum == computed_sum))
    else $error("checksum_ok disagrees with the sums");

  // A '$' always opens a sentence at position zero.
  a_start_pos: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_byte == CH_START |-> position == 7'd0)
    else $error("start character not at position zero");

endmodule

bind nmea_sentence_framer_checker nmeafc_checker u_nmeafc_checker (.*);

// ===== verif/nmea_sentence_framer_checker_tb.sv =====
// Self-checking testbench for the NMEA sentence framer and checksum checker.
`timescale 1ns / 100ps

module nmea_sentence_framer_checker_tb;
  import nmeafc_pkg::*;

  localparam int SENTENCE_LIMIT = MAX_SENTENCE_DEF;
  // Character count, over the whole run, at which random traffic stops.
  localparam int TOTAL_CHARS = 1500;
  localparam int MAX_PRINTED = 40;

  // Ways of closing a random sentence.
  typedef enum int {
    TAIL_GOOD,
    TAIL_BAD_SUM,
    TAIL_NONHEX,
    TAIL_BROKEN
  } tail_kind_t;

  // One expected result: a framed character and its sentence status.
  typedef struct packed {
    logic [7:0] ch;
    logic [6:0] pos;
    logic       done;
    logic       sum_ok;
    logic [7:0] rx_sum;
    logic [7:0] calc_sum;
  } framed_char_t;

  logic       clk;
  logic       rst;
  logic       rx_valid;
  logic       rx_stall;
  logic [7:0] in_byte;
  logic       res_valid;
  logic       res_stall;
  logic [7:0] out_byte;
  logic [6:0] position;
  logic       frame_end;
  logic       checksum_ok;
  logic [7:0] received_sum;
  logic [7:0] computed_sum;

  // Predicted framer state.
  bit         in_sentence;
  int         sentence_len;
  logic [7:0] sentence_xor;
  logic [7:0] last_five [TAIL_LEN];

  framed_char_t expected_chars [$];
  framed_char_t want_char;
  int           sent_count;
  int           mismatch_count;

  // Idling controls shared by the stimulus and the result stall process.
  bit sender_gaps_on;
  bit result_stalls_on;
  int hold_request;
  int stall_left;

  nmea_sentence_framer_checker #(
    .MAX_SENTENCE(SENTENCE_LIMIT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .rx_valid(rx_valid),
    .rx_stall(rx_stall),
    .in_byte(in_byte),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .out_byte(out_byte),
    .position(position),
    .frame_end(frame_end),
    .checksum_ok(checksum_ok),
    .received_sum(received_sum),
    .computed_sum(computed_sum)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Value of a hex digit, or 16 when the character is not one.
  function automatic int nibble_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return 16;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'("0") + 8'(n);
    return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
  endfunction

  // Short idle stretches mostly, a long one now and then.
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] text_sum(input string s);
    logic [7:0] x;
    x = '0;
    for (int i = 0; i < s.len(); i++) x ^= s[i];
    return x;
  endfunction

  // Sentence body character: mostly printable, sometimes any byte but '$'.
  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(8'h20, 8'h7E));
    end while (c == CH_START);
    return c;
  endfunction

  function automatic logic [7:0] nonhex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (nibble_value(c) < 16 || c == CH_START);
    return c;
  endfunction

  // Advances the predicted framer by one accepted character and queues the
  // expected result, if the character gives one.
  task automatic advance_framer(input logic [7:0] b);
    framed_char_t r;
    int           h1;
    int           h2;
    logic [7:0]   calc;
    if (b == CH_START) begin
      in_sentence  = 1'b1;
      sentence_len = 0;
      sentence_xor = '0;
      foreach (last_five[i]) last_five[i] = '0;
    end
    if (!in_sentence) return;
    // An overlong sentence drops this character and closes.
    if (sentence_len >= SENTENCE_LIMIT) begin
      in_sentence  = 1'b0;
      sentence_len = 0;
      return;
    end
    r = '0;
    r.ch  = b;
    r.pos = 7'(sentence_len);
    sentence_len++;
    sentence_xor ^= b;
    for (int i = 0; i < TAIL_LEN - 1; i++) last_five[i] = last_five[i + 1];
    last_five[TAIL_LEN - 1] = b;
    // Sentence closes on a '*hh CR LF' tail once long enough.
    if (sentence_len > MIN_FRAME && last_five[0] == CH_STAR &&
        last_five[3] == CH_CR && last_five[4] == CH_LF) begin
      h1   = nibble_value(last_five[1]);
      h2   = nibble_value(last_five[2]);
      calc = sentence_xor ^ CH_START;
      foreach (last_five[i]) calc ^= last_five[i];
      if (h1 > 15) r.rx_sum = '0;
      else if (h2 > 15) r.rx_sum = 8'(h1);
      else r.rx_sum = 8'(h1 * 16 + h2);
      r.done     = 1'b1;
      r.calc_sum = calc;
      r.sum_ok   = (r.rx_sum == calc);
      in_sentence  = 1'b0;
      sentence_len = 0;
    end
    expected_chars.push_back(r);
  endtask

  // Offers one character, waits for the request to be taken, then sometimes idles.
  task automatic send_char(input logic [7:0] b);
    int gap;
    rx_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    advance_framer(b);
    sent_count++;
    gap = (sender_gaps_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_nmea(input string body, input string sum_text);
    send_char(CH_START);
    for (int i = 0; i < body.len(); i++) send_char(body[i]);
    send_char(CH_STAR);
    send_char(sum_text[0]);
    send_char(sum_text[1]);
    send_char(CH_CR);
    send_char(CH_LF);
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic wait_for_results();
    rx_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h (char %0h pos %0d)",
                                name, got, want, want_char.ch, want_char.pos));
  endtask

  // Result side stall: a requested long hold, else random stall runs.
  initial begin
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else if (result_stalls_on && $urandom_range(0, 3) == 0) begin
        res_stall <= 1'b1;
        stall_left = idle_len() - 1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected result char %0h pos %0d", out_byte, position));
      end else begin
        want_char = expected_chars.pop_front();
        check_field("out_byte", out_byte, want_char.ch);
        check_field("position", 8'(position), 8'(want_char.pos));
        check_field("frame_end", 8'(frame_end), 8'(want_char.done));
        check_field("checksum_ok", 8'(checksum_ok), 8'(want_char.sum_ok));
        check_field("received_sum", received_sum, want_char.rx_sum);
        check_field("computed_sum", computed_sum, want_char.calc_sum);
      end
    end
  end

  // Characters outside any sentence give no result.
  task automatic test_outside_noise();
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_STAR);
    send_char(CH_CR);
    send_char(CH_LF);
    send_char("A");
    wait_for_results();
  endtask

  // Shortest closing sentence, a longer one, matching and wrong checksums.
  task automatic test_checksum_match();
    send_nmea("A", $sformatf("%02X", text_sum("A")));
    send_nmea("GPGLL,49,N", $sformatf("%02x", text_sum("GPGLL,49,N")));
    send_nmea("GPS,0", $sformatf("%02X", text_sum("GPS,0") ^ 8'h5A));
    wait_for_results();
  endtask

  // Six characters are too few to close; the sentence stays open.
  task automatic test_short_tail();
    send_nmea("", "00");
    send_char("B");
    send_char(8'h80);
    wait_for_results();
  endtask

  // Checksum characters that are not hex digits end the number early.
  task automatic test_nonhex_digits();
    send_nmea("AA", "Z9");
    send_nmea("GP", "G1");
    send_nmea("GP", "7z");
    send_nmea("XY", "fF");
    wait_for_results();
  endtask

  // A '$' inside an open sentence starts over at position 0.
  task automatic test_restart();
    send_char(CH_START);
    send_char("G");
    send_char("P");
    send_nmea("GPRMC,A", $sformatf("%02X", text_sum("GPRMC,A")));
    wait_for_results();
  endtask

  // Longest sentence that fits, then one that runs over the limit.
  task automatic test_long_sentence();
    send_char(CH_START);
    repeat (SENTENCE_LIMIT - 6) send_char("A");
    send_char(CH_STAR);
    send_char("0");
    send_char("0");
    send_char(CH_CR);
    send_char(CH_LF);
    send_char(CH_START);
    repeat (SENTENCE_LIMIT - 1) send_char("x");
    send_char(CH_STAR);
    send_char("A");
    wait_for_results();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    sender_gaps_on   = 1'b0;
    result_stalls_on = 1'b0;
    hold_request     = 300;
    repeat (3) send_nmea("GPGSV,3,1,11,03,03,111", $sformatf("%02X",
                         text_sum("GPGSV,3,1,11,03,03,111")));
    wait_for_results();
  endtask

  task automatic send_random_sentence();
    logic [7:0] body [$];
    logic [7:0] tail [TAIL_LEN];
    logic [7:0] sum;
    logic [7:0] b;
    int         pick;
    int         len;
    tail_kind_t kind;
    bit         lower;
    pick = $urandom_range(0, 99);
    if (pick < 88) len = $urandom_range(0, 16);
    else if (pick < 98) len = $urandom_range(17, 90);
    else len = $urandom_range(SENTENCE_LIMIT - 10, SENTENCE_LIMIT + 2);
    sum = '0;
    repeat (len) begin
      b = body_char();
      body.push_back(b);
      sum ^= b;
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) kind = TAIL_GOOD;
    else if (pick < 75) kind = TAIL_BAD_SUM;
    else if (pick < 85) kind = TAIL_NONHEX;
    else kind = TAIL_BROKEN;
    if (kind == TAIL_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
    lower = 1'($urandom_range(0, 1));
    tail = '{CH_STAR, hex_char(sum[7:4], lower), hex_char(sum[3:0], lower), CH_CR, CH_LF};
    if (kind == TAIL_NONHEX) tail[$urandom_range(1, 2)] = nonhex_char();
    if (kind == TAIL_BROKEN) tail[$urandom_range(0, 4)] = 8'($urandom_range(0, 255));
    send_char(CH_START);
    foreach (body[i]) send_char(body[i]);
    foreach (tail[i]) send_char(tail[i]);
  endtask

  // Mostly well-formed sentences with random content, plus line noise.
  task automatic test_random_traffic();
    while (sent_count < TOTAL_CHARS) begin
      if ($urandom_range(0, 49) == 0) begin
        sender_gaps_on   = $urandom_range(0, 2) != 0;
        result_stalls_on = $urandom_range(0, 2) != 0;
      end
      if ($urandom_range(0, 99) == 0) wait_for_results();
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
      end else begin
        send_random_sentence();
      end
    end
    wait_for_results();
  endtask

  initial begin
    rst              <= 1'b1;
    rx_valid         <= 1'b0;
    in_byte          <= '0;
    in_sentence      = 1'b0;
    sentence_len     = 0;
    sentence_xor     = '0;
    foreach (last_five[i]) last_five[i] = '0;
    sent_count       = 0;
    mismatch_count   = 0;
    hold_request     = 0;
    stall_left       = 0;
    sender_gaps_on   = 1'b1;
    result_stalls_on = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_outside_noise();
    test_checksum_match();
    test_short_tail();
    test_nonhex_digits();
    test_restart();
    test_long_sentence();
    test_backpressure();
    sender_gaps_on   = 1'b1;
    result_stalls_on = 1'b1;
    test_random_traffic();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== nmea_sentence_framer_checker.f =====
rtl/nmeafc_pkg.sv
rtl/nmeafc_tail_check.sv
rtl/nmea_sentence_framer_checker.sv
rtl/nmeafc_checker.sv
verif/nmea_sentence_framer_checker_tb.sv
